@@ rtl/lct_pkg.sv @@
// ----------------------------------------------------------------------------
// lct_pkg: shared definitions for the lru tag table
// Command codes and reserved tag and counter values.
// ----------------------------------------------------------------------------
package lct_pkg;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_ALLOC   = 3'd0;
  localparam cmd_t CMD_FIND    = 3'd1;
  localparam cmd_t CMD_VICTIM  = 3'd2;
  localparam cmd_t CMD_DISCARD = 3'd3;
  localparam cmd_t CMD_SET_TAG = 3'd4;

  localparam logic [31:0] TAG_INVALID  = 32'hFFFF_FFFF;
  localparam logic [31:0] TAG_RESERVED = 32'hFFFF_FFFE;
  localparam logic [31:0] RENUMBER_AT  = 32'hFFFF_FFFE;
  localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;

endpackage

@@ rtl/lct_ram.sv @@
// ----------------------------------------------------------------------------
// lct_ram: generic simple dual-port ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lru_cache_tag_table_core.sv @@
// ----------------------------------------------------------------------------
// lru_cache_tag_table_core: two fully associative lru tag tables
// Tags and timestamps live in rams; searching commands scan a table entry by entry.
//
// A command beat is taken when start is high and busy is low. Each command
// gives one result beat: done is high for one cycle with status and
// hit_entry; the receiver cannot stall, so results are never held.
// Discard all, set tag and unused codes finish at the accepting edge, the
// result showing in the next cycle. Allocate, find and victim scan the
// table through the tag and time rams, one entry a cycle on the shared
// read port, and stop early on a hit. When the use counter has reached
// 0xfffffffe, allocate and find first renumber the timestamps in place by
// a pairwise compare on the time ram, one entry a cycle, ranking each
// entry against every other before the ranks are written back.
// The next command may be taken in the cycle that carries the result.
// Reset (synchronous) marks every tag invalid and every time zero through
// per-entry valid bits, clears the use counters and idles the block; it
// needs no clearing pass.
// ----------------------------------------------------------------------------
module lru_cache_tag_table_core #(
  parameter int LINK_ENTRIES = 16,
  parameter int DATA_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic        table_req,
  input  logic [31:0] tag,
  input  logic [4:0]  entry_index,
  output logic        done,
  output logic        status,
  output logic [4:0]  hit_entry
);

  localparam int TOTAL   = LINK_ENTRIES + DATA_ENTRIES;
  localparam int MAX_N   = (LINK_ENTRIES > DATA_ENTRIES) ? LINK_ENTRIES : DATA_ENTRIES;
  localparam int ADDR_W  = $clog2(TOTAL);
  localparam int CNT_W   = $clog2(MAX_N + 1);
  localparam int RANK_AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  localparam logic [ADDR_W-1:0] LINK_BASE = ADDR_W'(LINK_ENTRIES);
  localparam logic [CNT_W-1:0]  LINK_N    = CNT_W'(LINK_ENTRIES);
  localparam logic [CNT_W-1:0]  DATA_N    = CNT_W'(DATA_ENTRIES);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_RN_LOAD = 3'd2;
  localparam logic [2:0] S_RN_HOLD = 3'd3;
  localparam logic [2:0] S_RN_CMP  = 3'd4;
  localparam logic [2:0] S_RN_WB   = 3'd5;

  logic [2:0]          state;
  lct_pkg::cmd_t       cmd_q;
  logic                t_q;
  logic [31:0]         tag_q;
  logic [CNT_W-1:0]    iss;
  logic                pend;
  logic [CNT_W-1:0]    pidx;
  logic [CNT_W-1:0]    ri;
  logic [31:0]         ti;
  logic [CNT_W-1:0]    rank_cnt;
  logic [31:0]         oldest;
  logic [CNT_W-1:0]    pick;
  logic                found;
  logic [ADDR_W-1:0]   raddr_q;
  logic [TOTAL-1:0]    tag_valid;
  logic [TOTAL-1:0]    time_valid;
  logic [31:0]         use_cnt [2];

  logic [ADDR_W-1:0]   base_in;
  logic [CNT_W-1:0]    n_in;
  logic [ADDR_W-1:0]   base_q;
  logic [CNT_W-1:0]    n_q;
  logic [CNT_W-1:0]    iss_lim;
  logic [ADDR_W-1:0]   raddr;
  logic [31:0]         tag_rdata;
  logic [31:0]         time_rdata;
  logic [31:0]         tag_eff;
  logic [31:0]         time_eff;
  logic [31:0]         cur_cnt;
  logic                accept;
  logic                set_in_range;

  logic                inv;
  logic                hit_now;
  logic                scan_end;
  logic                finish;
  logic                stamp_en;
  logic [CNT_W-1:0]    stamp_idx;
  logic                lt;
  logic [CNT_W-1:0]    rank_sum;
  logic                cmp_end;
  logic                wb_end;

  logic                tag_we;
  logic [ADDR_W-1:0]   tag_waddr;
  logic [31:0]         tag_wdata;
  logic                time_we;
  logic [ADDR_W-1:0]   time_waddr;
  logic [31:0]         time_wdata;
  logic                rank_we;
  logic [CNT_W-1:0]    rank_rdata;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign base_in = table_req ? LINK_BASE : '0;
  assign n_in    = table_req ? DATA_N : LINK_N;
  assign base_q  = t_q ? LINK_BASE : '0;
  assign n_q     = t_q ? DATA_N : LINK_N;
  assign iss_lim = (iss < n_q) ? iss : '0;
  assign cur_cnt = use_cnt[t_q];

  assign set_in_range = ({{CNT_W{1'b0}}, entry_index} < {5'b0, n_in});

  always_comb begin
    if (state == S_RN_LOAD) begin
      raddr = base_q + ADDR_W'(ri);
    end else begin
      raddr = base_q + ADDR_W'(iss_lim);
    end
  end

  assign tag_eff  = tag_valid[raddr_q] ? tag_rdata : lct_pkg::TAG_INVALID;
  assign time_eff = time_valid[raddr_q] ? time_rdata : 32'd0;

  // scan decisions
  assign inv     = (tag_eff == lct_pkg::TAG_INVALID);
  assign hit_now = (state == S_SCAN) && pend &&
                   (((cmd_q == lct_pkg::CMD_ALLOC) && inv) ||
                    ((cmd_q == lct_pkg::CMD_FIND) && (tag_eff == tag_q)) ||
                    ((cmd_q == lct_pkg::CMD_VICTIM) && inv));
  assign scan_end  = !pend && (iss == n_q);
  assign finish    = (state == S_SCAN) && (hit_now || scan_end);
  assign stamp_en  = finish && (hit_now || ((cmd_q == lct_pkg::CMD_VICTIM) && found));
  assign stamp_idx = hit_now ? pidx : pick;

  // renumber decisions
  assign lt       = pend && ((time_eff < ti) || ((time_eff == ti) && (pidx < ri)));
  assign rank_sum = rank_cnt + CNT_W'(lt);
  assign cmp_end  = !pend && (iss == n_q);
  assign wb_end   = !pend && (iss == n_q);
  assign rank_we  = (state == S_RN_CMP) && cmp_end;

  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = base_q + ADDR_W'(stamp_idx);
    tag_wdata = lct_pkg::TAG_RESERVED;
    if (accept && (cmd == lct_pkg::CMD_SET_TAG) && set_in_range) begin
      tag_we    = 1'b1;
      tag_waddr = base_in + ADDR_W'(entry_index);
      tag_wdata = tag;
    end else if (stamp_en && (cmd_q == lct_pkg::CMD_ALLOC)) begin
      tag_we    = 1'b1;
    end
  end

  always_comb begin
    time_we    = 1'b0;
    time_waddr = base_q + ADDR_W'(stamp_idx);
    time_wdata = cur_cnt;
    if (stamp_en) begin
      time_we    = 1'b1;
    end else if ((state == S_RN_WB) && pend) begin
      time_we    = 1'b1;
      time_waddr = base_q + ADDR_W'(pidx);
      time_wdata = 32'(rank_rdata);
    end
  end

  lct_ram #(.WIDTH(32), .DEPTH(TOTAL)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (raddr),
    .rdata (tag_rdata)
  );

  lct_ram #(.WIDTH(32), .DEPTH(TOTAL)) u_time_ram (
    .clk   (clk),
    .we    (time_we),
    .waddr (time_waddr),
    .wdata (time_wdata),
    .raddr (raddr),
    .rdata (time_rdata)
  );

  lct_ram #(.WIDTH(CNT_W), .DEPTH(MAX_N)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (ri[RANK_AW-1:0]),
    .wdata (rank_cnt),
    .raddr (iss_lim[RANK_AW-1:0]),
    .rdata (rank_rdata)
  );

  always_ff @(posedge clk) begin
    raddr_q <= raddr;
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      pend       <= 1'b0;
      tag_valid  <= '0;
      time_valid <= '0;
      use_cnt[0] <= 32'd0;
      use_cnt[1] <= 32'd0;
    end else begin
      done <= 1'b0;
      if (tag_we) begin
        tag_valid[tag_waddr] <= 1'b1;
      end
      if (time_we) begin
        time_valid[time_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q  <= cmd;
            t_q    <= table_req;
            tag_q  <= tag;
            iss    <= '0;
            pend   <= 1'b0;
            ri     <= '0;
            found  <= 1'b0;
            oldest <= lct_pkg::TIME_MAX;
            case (cmd)
              lct_pkg::CMD_ALLOC, lct_pkg::CMD_FIND: begin
                if (use_cnt[table_req] >= lct_pkg::RENUMBER_AT) begin
                  state <= S_RN_LOAD;
                end else begin
                  state <= S_SCAN;
                end
              end
              lct_pkg::CMD_VICTIM: begin
                state <= S_SCAN;
              end
              lct_pkg::CMD_DISCARD: begin
                for (int k = 0; k < TOTAL; k++) begin
                  if (table_req ? (k >= LINK_ENTRIES) : (k < LINK_ENTRIES)) begin
                    tag_valid[k] <= 1'b0;
                  end
                end
                use_cnt[table_req] <= 32'd0;
                done      <= 1'b1;
                status    <= 1'b0;
                hit_entry <= 5'd0;
              end
              lct_pkg::CMD_SET_TAG: begin
                done      <= 1'b1;
                status    <= !set_in_range;
                hit_entry <= entry_index;
              end
              default: begin
                done      <= 1'b1;
                status    <= 1'b1;
                hit_entry <= 5'd0;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (iss < n_q) begin
            iss <= iss + CNT_W'(1);
          end
          pend <= (iss < n_q);
          pidx <= iss;
          if (pend && (cmd_q == lct_pkg::CMD_VICTIM) && !inv && (time_eff < oldest)) begin
            oldest <= time_eff;
            pick   <= pidx;
            found  <= 1'b1;
          end
          if (finish) begin
            state     <= S_IDLE;
            done      <= 1'b1;
            status    <= !stamp_en;
            hit_entry <= stamp_en ? 5'(stamp_idx) : 5'd0;
            if (stamp_en) begin
              use_cnt[t_q] <= cur_cnt + 32'd1;
            end
          end
        end
        S_RN_LOAD: begin
          state <= S_RN_HOLD;
        end
        S_RN_HOLD: begin
          ti       <= time_eff;
          iss      <= '0;
          pend     <= 1'b0;
          rank_cnt <= '0;
          state    <= S_RN_CMP;
        end
        S_RN_CMP: begin
          if (iss < n_q) begin
            iss <= iss + CNT_W'(1);
          end
          pend     <= (iss < n_q);
          pidx     <= iss;
          rank_cnt <= rank_sum;
          if (cmp_end) begin
            ri <= ri + CNT_W'(1);
            if ((ri + CNT_W'(1)) == n_q) begin
              iss   <= '0;
              pend  <= 1'b0;
              state <= S_RN_WB;
            end else begin
              state <= S_RN_LOAD;
            end
          end
        end
        S_RN_WB: begin
          if (iss < n_q) begin
            iss <= iss + CNT_W'(1);
          end
          pend <= (iss < n_q);
          pidx <= iss;
          if (wb_end) begin
            use_cnt[t_q] <= 32'(n_q);
            iss   <= '0;
            pend  <= 1'b0;
            state <= S_SCAN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // assertions
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !busy)
    else $error("block left idle without a command beat");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_RN_CMP || state == S_RN_WB) |-> (iss <= n_q))
    else $error("scan index ran past the table");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    rank_we |-> (rank_cnt < n_q))
    else $error("rank out of range");

  a_renumber_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && $past(state) == S_RN_WB) |-> (use_cnt[t_q] == 32'(n_q)))
    else $error("use counter not reloaded after renumbering");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: lru tag table core
// Drives allocate, find, victim, discard and set tag beats into both tables,
// predicts every reply from a private copy of the tags, timestamps and use
// counters, and compares each done beat with the oldest pending reply.
// ----------------------------------------------------------------------------
module testbench;

  localparam int   LINK_N = 16;
  localparam int   DATA_N = 32;
  localparam logic TBL_LINK = 1'b0;
  localparam logic TBL_DATA = 1'b1;
  localparam lct_pkg::cmd_t CMD_UNUSED_LO = 3'd5;
  localparam lct_pkg::cmd_t CMD_UNUSED_HI = 3'd7;
  localparam int   RANDOM_BEATS = 1700;

  typedef struct packed {
    logic       status;
    logic [4:0] hit;
  } reply_t;

  class lru_tag_board;
    logic [31:0] entry_tag [LINK_N + DATA_N];
    logic [31:0] entry_stamp [LINK_N + DATA_N];
    logic [31:0] use_count [2];
    reply_t      pending_replies [$];
    int          mismatches;

    function new();
      foreach (entry_tag[i]) begin
        entry_tag[i]   = lct_pkg::TAG_INVALID;
        entry_stamp[i] = '0;
      end
      use_count[0] = '0;
      use_count[1] = '0;
      mismatches   = 0;
    endfunction

    function void rerank(int base, int n, logic tbl);
      logic [31:0] rank [64];
      int          r;
      if (use_count[tbl] < lct_pkg::RENUMBER_AT) return;
      for (int i = 0; i < n; i++) begin
        r = 0;
        for (int j = 0; j < n; j++) begin
          if (entry_stamp[base + j] < entry_stamp[base + i] ||
              (entry_stamp[base + j] == entry_stamp[base + i] && j < i)) r++;
        end
        rank[i] = r;
      end
      for (int i = 0; i < n; i++) entry_stamp[base + i] = rank[i];
      use_count[tbl] = n;
    endfunction

    function void touch(int pos, logic tbl);
      entry_stamp[pos] = use_count[tbl];
      use_count[tbl]   = use_count[tbl] + 1;
    endfunction

    function void note_command(lct_pkg::cmd_t c, logic tbl, logic [31:0] tg,
                               logic [4:0] ix);
      int          base;
      int          n;
      int          pick;
      bit          found;
      logic [31:0] oldest;
      reply_t      r;
      base     = (tbl == TBL_DATA) ? LINK_N : 0;
      n        = (tbl == TBL_DATA) ? DATA_N : LINK_N;
      r.status = 1'b1;
      r.hit    = '0;
      pick     = 0;
      found    = 1'b0;
      oldest   = lct_pkg::TIME_MAX;
      case (c)
        lct_pkg::CMD_ALLOC: begin
          rerank(base, n, tbl);
          for (int i = 0; i < n; i++) begin
            if (entry_tag[base + i] == lct_pkg::TAG_INVALID) begin
              entry_tag[base + i] = lct_pkg::TAG_RESERVED;
              touch(base + i, tbl);
              r.status = 1'b0;
              r.hit    = 5'(i);
              break;
            end
          end
        end
        lct_pkg::CMD_FIND: begin
          rerank(base, n, tbl);
          for (int i = 0; i < n; i++) begin
            if (entry_tag[base + i] == tg) begin
              touch(base + i, tbl);
              r.status = 1'b0;
              r.hit    = 5'(i);
              break;
            end
          end
        end
        lct_pkg::CMD_VICTIM: begin
          for (int i = 0; i < n; i++) begin
            if (entry_tag[base + i] == lct_pkg::TAG_INVALID) begin
              pick  = i;
              found = 1'b1;
              break;
            end
            if (entry_stamp[base + i] < oldest) begin
              oldest = entry_stamp[base + i];
              pick   = i;
              found  = 1'b1;
            end
          end
          if (found) begin
            touch(base + pick, tbl);
            r.status = 1'b0;
            r.hit    = 5'(pick);
          end
        end
        lct_pkg::CMD_DISCARD: begin
          for (int i = 0; i < n; i++) entry_tag[base + i] = lct_pkg::TAG_INVALID;
          use_count[tbl] = '0;
          r.status = 1'b0;
        end
        lct_pkg::CMD_SET_TAG: begin
          r.hit = ix;
          if (int'(ix) < n) begin
            entry_tag[base + ix] = tg;
            r.status = 1'b0;
          end
        end
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void flag(string what, reply_t want, logic st, logic [4:0] hit);
      if (mismatches < 10)
        $display("%0t: %s: expected status %0b hit %0d, got status %0b hit %0d",
                 $realtime, what, want.status, want.hit, st, hit);
      mismatches++;
    endfunction

    function void check_reply(logic st, logic [4:0] hit);
      reply_t want;
      if (pending_replies.size() == 0) begin
        want = '0;
        flag("reply with nothing pending", want, st, hit);
        return;
      end
      want = pending_replies.pop_front();
      if (want.status !== st || want.hit !== hit) flag("reply mismatch", want, st, hit);
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  lct_pkg::cmd_t cmd = lct_pkg::CMD_ALLOC;
  logic          table_req = TBL_LINK;
  logic [31:0]   tag = '0;
  logic [4:0]    entry_index = '0;
  logic          done;
  logic          status;
  logic [4:0]    hit_entry;

  lru_tag_board board = new();
  int           idle_pct = 9;
  logic [31:0]  tag_pool [8];

  lru_cache_tag_table_core #(
    .LINK_ENTRIES(LINK_N),
    .DATA_ENTRIES(DATA_N)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .table_req  (table_req),
    .tag        (tag),
    .entry_index(entry_index),
    .done       (done),
    .status     (status),
    .hit_entry  (hit_entry)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_reply(status, hit_entry);
  end

  task automatic issue_command(lct_pkg::cmd_t c, logic tbl, logic [31:0] tg,
                               logic [4:0] ix);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    cmd         <= c;
    table_req   <= tbl;
    tag         <= tg;
    entry_index <= ix;
    do @(posedge clk); while (busy);
    board.note_command(c, tbl, tg, ix);
  endtask

  function automatic logic [31:0] pool_tag();
    int r;
    r = $urandom_range(99);
    if (r < 60) return tag_pool[$urandom_range(7)];
    if (r < 70) return lct_pkg::TAG_INVALID;
    if (r < 78) return lct_pkg::TAG_RESERVED;
    return $urandom();
  endfunction

  task automatic random_command();
    int            pick;
    lct_pkg::cmd_t c;
    logic          tbl;
    logic [4:0]    ix;
    logic [31:0]   tg;
    pick = $urandom_range(99);
    tbl  = 1'($urandom_range(1));
    ix   = 5'($urandom_range(31));
    tg   = pool_tag();
    if (pick < 20)      c = lct_pkg::CMD_ALLOC;
    else if (pick < 48) c = lct_pkg::CMD_FIND;
    else if (pick < 63) c = lct_pkg::CMD_VICTIM;
    else if (pick < 65) c = lct_pkg::CMD_DISCARD;
    else if (pick < 97) c = lct_pkg::CMD_SET_TAG;
    else                c = lct_pkg::cmd_t'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    issue_command(c, tbl, tg, ix);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the link table, then overflow it
    for (int i = 0; i < LINK_N; i++) issue_command(lct_pkg::CMD_ALLOC, TBL_LINK, '0, '0);
    issue_command(lct_pkg::CMD_ALLOC, TBL_LINK, '0, '0);
    issue_command(lct_pkg::CMD_VICTIM, TBL_LINK, '0, '0);
    issue_command(lct_pkg::CMD_FIND, TBL_LINK, lct_pkg::TAG_RESERVED, '0);
    issue_command(lct_pkg::CMD_SET_TAG, TBL_LINK, 32'h1234_5678, 5'd16);
    issue_command(lct_pkg::CMD_SET_TAG, TBL_LINK, lct_pkg::TAG_INVALID, 5'd15);
    issue_command(lct_pkg::CMD_FIND, TBL_LINK, lct_pkg::TAG_INVALID, '0);
    issue_command(lct_pkg::CMD_SET_TAG, TBL_DATA, 32'h0000_0000, 5'd31);
    issue_command(lct_pkg::CMD_FIND, TBL_DATA, 32'h0000_0000, '0);
    issue_command(lct_pkg::CMD_FIND, TBL_DATA, 32'hDEAD_BEEF, '0);
    issue_command(lct_pkg::CMD_VICTIM, TBL_DATA, 32'hFFFF_0000, 5'd31);
    issue_command(CMD_UNUSED_LO, TBL_DATA, 32'hFFFF_FFFF, 5'd31);
    issue_command(CMD_UNUSED_HI, TBL_LINK, '0, '0);
    issue_command(lct_pkg::CMD_DISCARD, TBL_LINK, '0, '0);
    issue_command(lct_pkg::CMD_DISCARD, TBL_DATA, '0, '0);

    foreach (tag_pool[i]) tag_pool[i] = $urandom();
    tag_pool[0] = 32'h0000_0000;
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      if (k == RANDOM_BEATS / 3) idle_pct = 65;
      if (k == 2 * RANDOM_BEATS / 3) idle_pct = 0;
      random_command();
    end
    start <= 1'b0;

    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.pending_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
